// File: rtl/core/umlcd_pkg.sv
// Shared types, codes and constant tables for the USB-MIDI LED command decoder.
// No dependencies; used by every module in rtl/core.
package umlcd_pkg;

  // USB-MIDI code index numbers
  localparam logic [3:0] CIN_SYSEX    = 4'd4;
  localparam logic [3:0] CIN_END1     = 4'd5;
  localparam logic [3:0] CIN_END2     = 4'd6;
  localparam logic [3:0] CIN_END3     = 4'd7;
  localparam logic [3:0] CIN_NOTE_OFF = 4'd8;
  localparam logic [3:0] CIN_NOTE_ON  = 4'd9;
  localparam logic [3:0] CIN_CC       = 4'd11;

  localparam int HEAD_DEPTH  = 16;
  localparam int COUNT_W     = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // sysex message types and text commands
  localparam logic [7:0] MSG_TEXT    = 8'h14;
  localparam logic [7:0] MSG_LAYOUT  = 8'h22;
  localparam logic [7:0] MSG_CHAL    = 8'h40;
  localparam logic [7:0] CMD_STATE   = 8'h73; // 's'
  localparam logic [7:0] CMD_TEMPO   = 8'h54; // 'T'
  localparam logic [7:0] CH_PLAY     = 8'h50; // 'P'
  localparam logic [7:0] CH_REC      = 8'h52; // 'R'
  localparam logic [7:0] CH_SESS     = 8'h53; // 'S'
  localparam logic [7:0] CH_DOWN     = 8'h44; // 'D'
  localparam logic [7:0] CH_UP       = 8'h55; // 'U'
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;

  // control change range for the device control column
  localparam logic [7:0] CTL_LOW  = 8'd104;
  localparam logic [7:0] CTL_HIGH = 8'd111;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_NOTE,
    KIND_CC,
    KIND_SYSEX
  } pkt_kind_e;

  typedef struct packed {
    pkt_kind_e  kind;
    logic [1:0] sx_len;  // sysex bytes carried
    logic       sx_end;  // sysex terminating packet
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;      // velocity already zeroed for note off
  } pkt_t;

  typedef struct packed {
    logic        led_write;
    logic [3:0]  led_column;
    logic [2:0]  led_row;
    logic [6:0]  color_index;
    logic [3:0]  lighting_type;
    logic        challenge_reply;
    logic [1:0]  layout;
    logic [15:0] tempo;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator;
    logic [4:0]  transport_flags;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    case (idx)
      3'd0:    hdr_byte = 8'hF0;
      3'd1:    hdr_byte = 8'h00;
      3'd2:    hdr_byte = 8'h20;
      3'd3:    hdr_byte = 8'h29;
      3'd4:    hdr_byte = 8'h02;
      3'd5:    hdr_byte = 8'h18;
      default: hdr_byte = 8'h00;
    endcase
  endfunction

  // row of each device control number, offset from CTL_LOW
  function automatic logic [2:0] ctl_row(input logic [2:0] idx);
    case (idx)
      3'd0:    ctl_row = 3'd4;
      3'd1:    ctl_row = 3'd7;
      3'd2:    ctl_row = 3'd5;
      3'd3:    ctl_row = 3'd6;
      3'd4:    ctl_row = 3'd3;
      3'd5:    ctl_row = 3'd2;
      3'd6:    ctl_row = 3'd0;
      default: ctl_row = 3'd1;
    endcase
  endfunction

endpackage

// File: rtl/core/usb_midi_led_command_decoder.sv
// USB-MIDI LED command decoder, top level.
// Path from packet accept to result valid: front register, queue, back-end output
// register. Throughput: one packet per cycle while m_axis_tready does not stall the
// output, set by the combinational decode and message handling in the back end.
// Reset: asynchronous, active low; clears layout, sysex count, tempo,
// signature and flags at once. The sysex head capture is not cleared.
module usb_midi_led_command_decoder import umlcd_pkg::*; #(
  parameter int SYSEX_LIMIT = 64,
  parameter int MAX_LAYOUT  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // byte_zero[7:0], byte_one[15:8], byte_two[23:16]
  input  logic [3:0]  s_axis_tuser,  // code_index[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_column[3:0], led_row[6:4], color_index[13:7], lighting_type[17:14],
  // challenge_reply[18], layout[20:19], tempo[36:21], sig_numerator[44:37],
  // sig_denominator[52:45], transport_flags[57:53], zero fill above
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser   // led_write[0]
);

  logic    push, push_ready, pop_valid, pop;
  pkt_t    push_pkt, pop_pkt;
  result_t res;

  umlcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .code_index_i (s_axis_tuser),
    .byte_zero_i  (s_axis_tdata[7:0]),
    .byte_one_i   (s_axis_tdata[15:8]),
    .byte_two_i   (s_axis_tdata[23:16]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .pkt_o        (push_pkt)
  );

  umlcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_pkt_i   (push_pkt),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_pkt_o    (pop_pkt)
  );

  umlcd_back #(
    .SYSEX_LIMIT (SYSEX_LIMIT),
    .MAX_LAYOUT  (MAX_LAYOUT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pop_valid),
    .pkt_pop_o   (pop),
    .pkt_i       (pop_pkt),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.led_write;
  assign m_axis_tdata = {6'd0, res.transport_flags, res.sig_denominator,
                         res.sig_numerator, res.tempo, res.layout,
                         res.challenge_reply, res.lighting_type, res.color_index,
                         res.led_row, res.led_column};

endmodule

// File: rtl/core/umlcd_front.sv
// Front end: accepts event packets, classifies them and registers one word.
// Depends on umlcd_pkg.
module umlcd_front import umlcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] code_index_i,
  input  logic [7:0] byte_zero_i,
  input  logic [7:0] byte_one_i,
  input  logic [7:0] byte_two_i,
  output logic       push_o,
  input  logic       push_ready_i,
  output pkt_t       pkt_o
);

  logic valid_q, valid_d;
  pkt_t pkt_q, pkt_d;

  always_comb begin
    pkt_d.kind   = KIND_NONE;
    pkt_d.sx_len = 2'd0;
    pkt_d.sx_end = 1'b0;
    pkt_d.b0     = byte_zero_i;
    pkt_d.b1     = byte_one_i;
    pkt_d.b2     = byte_two_i;
    case (code_index_i)
      CIN_NOTE_OFF: begin
        pkt_d.kind = KIND_NOTE;
        pkt_d.b2   = 8'd0;
      end
      CIN_NOTE_ON: pkt_d.kind = KIND_NOTE;
      CIN_CC:      pkt_d.kind = KIND_CC;
      CIN_SYSEX: begin
        pkt_d.kind   = KIND_SYSEX;
        pkt_d.sx_len = 2'd3;
      end
      CIN_END1: begin
        pkt_d.kind   = KIND_SYSEX;
        pkt_d.sx_len = 2'd1;
        pkt_d.sx_end = 1'b1;
      end
      CIN_END2: begin
        pkt_d.kind   = KIND_SYSEX;
        pkt_d.sx_len = 2'd2;
        pkt_d.sx_end = 1'b1;
      end
      CIN_END3: begin
        pkt_d.kind   = KIND_SYSEX;
        pkt_d.sx_len = 2'd3;
        pkt_d.sx_end = 1'b1;
      end
      default: pkt_d.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o = !valid_q || push_ready_i;
  assign push_o     = valid_q;
  assign pkt_o      = pkt_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q <= pkt_d;
    end
  end

endmodule

// File: rtl/core/umlcd_queue.sv
// Short word queue between front and back end, first in first out.
// Depends on umlcd_pkg.
module umlcd_queue import umlcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic push_ready_o,
  input  pkt_t push_pkt_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output pkt_t pop_pkt_o
);

  pkt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;
  logic              do_push, do_pop;

  assign push_ready_o = fill_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_pkt_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

endmodule

// File: rtl/core/umlcd_back.sv
// Back end: note and control decode, sysex capture and message handling,
// device state and the output register. Depends on umlcd_pkg.
module umlcd_back import umlcd_pkg::*; #(
  parameter int SYSEX_LIMIT = 64,
  parameter int MAX_LAYOUT  = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    pkt_valid_i,
  output logic    pkt_pop_o,
  input  pkt_t    pkt_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam logic [COUNT_W-1:0] CountStop = COUNT_W'(SYSEX_LIMIT - 3);
  localparam logic [7:0]         LayoutTop = 8'(MAX_LAYOUT);

  logic [1:0]         layout_q, layout_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [15:0]        tempo_q, tempo_d;
  logic [7:0]         num_q, num_d;
  logic [7:0]         den_q, den_d;
  logic [4:0]         flags_q, flags_d;
  logic [7:0]         head_q [HEAD_DEPTH];
  logic [7:0]         head_d [HEAD_DEPTH];
  logic               head_we;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  // note decode
  logic [15:0] note_prod;
  logic [4:0]  note_tens;
  logic [7:0]  note_unit;
  logic [7:0]  note_off36, note_off68, note_off107;
  // sysex
  logic               overflow;
  logic [COUNT_W-1:0] msg_len, msg_len_m1;
  logic [7:0]         mb [HEAD_DEPTH];
  logic               hdr_ok;
  logic [15:0]        tempo_calc;
  logic [7:0]         num_calc, den_calc;

  assign pkt_pop_o   = pkt_valid_i && (!out_valid_q || res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // divide by ten through the reciprocal 205/2048, exact for 8-bit notes
  assign note_prod   = {8'd0, pkt_i.b1} * 16'd205;
  assign note_tens   = note_prod[15:11];
  assign note_unit   = pkt_i.b1 - 8'({3'd0, note_tens} * 8'd10);
  assign note_off36  = pkt_i.b1 - 8'd36;
  assign note_off68  = pkt_i.b1 - 8'd68;
  assign note_off107 = 8'd107 - pkt_i.b1;

  assign overflow   = count_q >= CountStop;
  assign msg_len    = count_q + COUNT_W'(pkt_i.sx_len);
  assign msg_len_m1 = msg_len - 1'b1;

  // merge this word's bytes into the head capture
  always_comb begin
    for (int k = 0; k < HEAD_DEPTH; k++) begin
      head_d[k] = head_q[k];
      if (count_q == COUNT_W'(k)) begin
        head_d[k] = pkt_i.b0;
      end else if (pkt_i.sx_len >= 2'd2 && count_q + 1'b1 == COUNT_W'(k)) begin
        head_d[k] = pkt_i.b1;
      end else if (pkt_i.sx_len == 2'd3 && count_q + 2'd2 == COUNT_W'(k)) begin
        head_d[k] = pkt_i.b2;
      end
    end
  end

  // bytes at or past the terminator read as zero
  always_comb begin
    for (int k = 0; k < HEAD_DEPTH; k++) begin
      mb[k] = (COUNT_W'(k) < msg_len_m1) ? head_d[k] : 8'd0;
    end
    hdr_ok = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (head_d[k] != hdr_byte(3'(k))) begin
        hdr_ok = 1'b0;
      end
    end
  end

  assign tempo_calc = 16'(({8'd0, mb[8]} - 16'd48) * 16'd100)
                    + 16'(({8'd0, mb[9]} - 16'd48) * 16'd10)
                    + ({8'd0, mb[10]} - 16'd48);
  assign num_calc   = 8'((mb[11] - DIGIT_ZERO) * 8'd10) + (mb[12] - DIGIT_ZERO);
  assign den_calc   = 8'((mb[13] - DIGIT_ZERO) * 8'd10) + (mb[14] - DIGIT_ZERO);

  always_comb begin
    layout_d = layout_q;
    count_d  = count_q;
    tempo_d  = tempo_q;
    num_d    = num_q;
    den_d    = den_q;
    flags_d  = flags_q;
    head_we  = 1'b0;
    res_d    = '0;

    case (pkt_i.kind)
      KIND_NOTE: begin
        if (layout_q == 2'd1) begin
          if (pkt_i.b1 >= 8'd36 && pkt_i.b1 <= 8'd67) begin
            res_d.led_write  = 1'b1;
            res_d.led_column = {2'b00, pkt_i.b1[1:0]};
            res_d.led_row    = note_off36[4:2];
          end else if (pkt_i.b1 >= 8'd68 && pkt_i.b1 <= 8'd99) begin
            res_d.led_write  = 1'b1;
            res_d.led_column = {2'b01, pkt_i.b1[1:0]};
            res_d.led_row    = note_off68[4:2];
          end else if (pkt_i.b1 >= 8'd100 && pkt_i.b1 <= 8'd107) begin
            res_d.led_write  = 1'b1;
            res_d.led_column = 4'd8;
            res_d.led_row    = note_off107[2:0];
          end
        end else if (pkt_i.b1 >= 8'd11 && pkt_i.b1 <= 8'd89 && note_unit != 8'd0) begin
          res_d.led_write  = 1'b1;
          res_d.led_column = 4'(note_unit - 8'd1);
          res_d.led_row    = 3'(note_tens - 5'd1);
        end
        if (pkt_i.b2[7]) begin
          res_d.led_write = 1'b0;
        end
        if (res_d.led_write) begin
          res_d.color_index   = pkt_i.b2[6:0];
          res_d.lighting_type = (pkt_i.b0[3:0] <= 4'd2) ? pkt_i.b0[3:0] : 4'd0;
        end else begin
          res_d.led_column = 4'd0;
          res_d.led_row    = 3'd0;
        end
      end
      KIND_CC: begin
        if (pkt_i.b1 >= CTL_LOW && pkt_i.b1 <= CTL_HIGH && !pkt_i.b2[7]) begin
          res_d.led_write     = 1'b1;
          res_d.led_column    = 4'd9;
          res_d.led_row       = ctl_row(pkt_i.b1[2:0]);
          res_d.color_index   = pkt_i.b2[6:0];
          res_d.lighting_type = pkt_i.b0[3:0];
        end
      end
      KIND_SYSEX: begin
        if (overflow) begin
          count_d = '0;
        end else begin
          head_we = 1'b1;
          count_d = msg_len;
          if (pkt_i.sx_end) begin
            count_d = '0;
            if (msg_len >= COUNT_W'(8) && hdr_ok) begin
              case (head_d[6])
                MSG_LAYOUT: begin
                  if (head_d[7] <= LayoutTop) begin
                    layout_d = head_d[7][1:0];
                  end
                end
                MSG_CHAL: res_d.challenge_reply = 1'b1;
                MSG_TEXT: begin
                  if (mb[7] == CMD_STATE) begin
                    flags_d = {flags_q[4:3], mb[10] == CH_SESS, mb[9] == CH_REC,
                               mb[8] == CH_PLAY};
                  end else if (mb[7] == CMD_TEMPO) begin
                    tempo_d = tempo_calc;
                    num_d   = num_calc;
                    den_d   = den_calc;
                    flags_d = {mb[15] == CH_UP, mb[15] == CH_DOWN, flags_q[2:0]};
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase

    res_d.layout          = layout_d;
    res_d.tempo           = tempo_d;
    res_d.sig_numerator   = num_d;
    res_d.sig_denominator = den_d;
    res_d.transport_flags = flags_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pkt_pop_o) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= 2'd0;
      count_q     <= '0;
      tempo_q     <= 16'd0;
      num_q       <= 8'd0;
      den_q       <= 8'd0;
      flags_q     <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pkt_pop_o) begin
        layout_q <= layout_d;
        count_q  <= count_d;
        tempo_q  <= tempo_d;
        num_q    <= num_d;
        den_q    <= den_d;
        flags_q  <= flags_d;
      end
    end
  end

  // head capture and result word carry no reset
  always_ff @(posedge clk_i) begin
    if (pkt_pop_o) begin
      res_q <= res_d;
      if (head_we) begin
        for (int k = 0; k < HEAD_DEPTH; k++) begin
          head_q[k] <= head_d[k];
        end
      end
    end
  end

endmodule

// File: test/usb_midi_led_command_decoder_tb.sv
// Self-checking testbench for the USB-MIDI LED command decoder.
// Drives event packets on the input stream and checks every output word against a
// behavioural predictor or a directed row's expected word. Needs umlcd_pkg and the RTL.
`timescale 1ns / 100ps

module usb_midi_led_command_decoder_tb;
  import umlcd_pkg::*;

  localparam int SYSEX_LIMIT  = 64;
  localparam int MAX_LAYOUT   = 2;
  localparam int IDLE_PCT     = 27;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 40;

  localparam logic [3:0] CIN_RESERVED = 4'd15;
  localparam logic [7:0] SYSEX_EOX    = 8'hF7;
  localparam logic [1:0] LAYOUT_DRUM  = 2'd1;

  localparam int FLAG_PLAY = 0;
  localparam int FLAG_REC  = 1;
  localparam int FLAG_SESS = 2;
  localparam int FLAG_DOWN = 3;
  localparam int FLAG_UP   = 4;

  localparam logic [7:0] SYSEX_HDR [6] = '{8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18};
  localparam logic [2:0] CTL_ROW_MAP [8] = '{3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1};

  typedef struct packed {
    logic [3:0] cin;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       typed;
    result_t    want;
  } stim_row_t;

  function automatic result_t led_at(input int col, input int row, input int color,
                                     input int light);
    result_t r;
    r = '0;
    r.led_write     = 1'b1;
    r.led_column    = 4'(col);
    r.led_row       = 3'(row);
    r.color_index   = 7'(color);
    r.lighting_type = 4'(light);
    return r;
  endfunction

  function automatic stim_row_t pkt(input logic [3:0] cin, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2);
    return '{cin: cin, b0: b0, b1: b1, b2: b2, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t pkt_chk(input logic [3:0] cin, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input result_t want);
    return '{cin: cin, b0: b0, b1: b1, b2: b2, typed: 1'b1, want: want};
  endfunction

  // First rows run straight after reset, so the state fields are all zero there.
  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    pkt_chk(CIN_NOTE_ON,  8'h00, 8'd11,  8'd127, led_at(0, 0, 127, 0)),
    pkt_chk(CIN_NOTE_ON,  8'h02, 8'd89,  8'd1,   led_at(8, 7, 1, 2)),
    pkt_chk(CIN_NOTE_ON,  8'h00, 8'd20,  8'd5,   '0),  // last digit zero
    pkt_chk(CIN_NOTE_ON,  8'hFF, 8'hFF,  8'hFF,  '0),
    pkt_chk(CIN_NOTE_ON,  8'h00, 8'd11,  8'd128, '0),  // velocity out of range
    pkt_chk(CIN_NOTE_OFF, 8'h01, 8'd55,  8'd100, led_at(4, 4, 0, 1)),
    pkt_chk(CIN_CC,       8'h0F, 8'd111, 8'd127, led_at(9, 1, 127, 15)),
    pkt_chk(CIN_CC,       8'h00, 8'd104, 8'd0,   led_at(9, 4, 0, 0)),
    pkt_chk(CIN_CC,       8'h00, 8'd103, 8'd1,   '0),
    pkt_chk(CIN_CC,       8'h00, 8'd105, 8'd128, '0),
    pkt_chk(4'd0,         8'hFF, 8'hFF,  8'hFF,  '0),
    pkt_chk(CIN_RESERVED, 8'hFF, 8'hFF,  8'hFF,  '0),
    pkt_chk(CIN_END1,     SYSEX_EOX, 8'h00, 8'h00, '0),  // lone terminator
    // layout select: drum layout
    pkt(CIN_SYSEX,    8'hF0, 8'h00, 8'h20),
    pkt(CIN_SYSEX,    8'h29, 8'h02, 8'h18),
    pkt(CIN_END3,     MSG_LAYOUT, 8'h01, SYSEX_EOX),
    pkt(CIN_NOTE_ON,  8'h00, 8'd36,  8'd10),
    pkt(CIN_NOTE_ON,  8'h02, 8'd99,  8'd127),
    pkt(CIN_NOTE_ON,  8'h01, 8'd107, 8'd64),
    // challenge request
    pkt(CIN_SYSEX,    8'hF0, 8'h00, 8'h20),
    pkt(CIN_SYSEX,    8'h29, 8'h02, 8'h18),
    pkt(CIN_END2,     MSG_CHAL, SYSEX_EOX, 8'h00),
    // tempo text "T120" "04" "04" "U", 17 bytes so the flag sits in the last captured slot
    pkt(CIN_SYSEX,    8'hF0, 8'h00, 8'h20),
    pkt(CIN_SYSEX,    8'h29, 8'h02, 8'h18),
    pkt(CIN_SYSEX,    MSG_TEXT, CMD_TEMPO, 8'h31),
    pkt(CIN_SYSEX,    8'h32, 8'h30, 8'h30),
    pkt(CIN_SYSEX,    8'h34, 8'h30, 8'h34)
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // byte_zero[7:0], byte_one[15:8], byte_two[23:16]
  logic [3:0]  s_axis_tuser;   // code_index[3:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // led_column[3:0], led_row[6:4], color_index[13:7], lighting_type[17:14],
  // challenge_reply[18], layout[20:19], tempo[36:21], sig_numerator[44:37],
  // sig_denominator[52:45], transport_flags[57:53], zero fill above
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;   // led_write[0]

  usb_midi_led_command_decoder #(
    .SYSEX_LIMIT(SYSEX_LIMIT),
    .MAX_LAYOUT (MAX_LAYOUT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow copy of the decoder state
  logic [1:0]  sh_layout;
  logic [6:0]  sh_count;
  logic [7:0]  sh_head [HEAD_DEPTH];
  logic [15:0] sh_tempo;
  logic [7:0]  sh_numer;
  logic [7:0]  sh_denom;
  logic [4:0]  sh_flags;

  result_t     pending_results [$];
  logic [7:0]  sysex_buf [$];

  bit          calm;
  int          err_count;
  int          cycle_count;
  int          packets_sent;
  int          results_seen;
  int          led_writes_seen;
  int          challenges_seen;
  int          messages_sent;
  result_t     mon_got;
  result_t     mon_want;

  function automatic void store_byte(input logic [7:0] b);
    if (sh_count < HEAD_DEPTH) sh_head[sh_count[3:0]] = b;
    sh_count = sh_count + 7'd1;
  endfunction

  // bytes at or past the terminator, or beyond the capture, read as zero
  function automatic logic [7:0] head_at(input int k, input int len);
    if (len == 0 || k >= len - 1 || k >= HEAD_DEPTH) return 8'h00;
    return sh_head[k];
  endfunction

  function automatic logic [31:0] digit_at(input int k, input int len);
    return 32'(head_at(k, len)) - 32'd48;
  endfunction

  function automatic result_t decode_packet(input logic [3:0] cin, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2);
    result_t     r;
    int          note;
    int          vel;
    int          chan;
    int          len;
    int          i;
    bit          ok;
    bit          hdr_ok;
    logic [7:0]  cmd;
    logic [7:0]  ctl_off;
    logic [31:0] t;
    r    = '0;
    chan = int'(b0[3:0]);
    if (cin == CIN_NOTE_OFF || cin == CIN_NOTE_ON) begin
      note = int'(b1);
      vel  = (cin == CIN_NOTE_ON) ? int'(b2) : 0;
      ok   = 1'b0;
      if (sh_layout == LAYOUT_DRUM) begin
        if (note >= 36 && note <= 67) begin
          r.led_column = 4'(note % 4);
          r.led_row    = 3'((note - 36) / 4);
          ok = 1'b1;
        end else if (note >= 68 && note <= 99) begin
          r.led_column = 4'(note % 4 + 4);
          r.led_row    = 3'((note - 68) / 4);
          ok = 1'b1;
        end else if (note >= 100 && note <= 107) begin
          r.led_column = 4'd8;
          r.led_row    = 3'(107 - note);
          ok = 1'b1;
        end
      end else if (note >= 11 && note <= 89 && note % 10 != 0) begin
        r.led_column = 4'(note % 10 - 1);
        r.led_row    = 3'(note / 10 - 1);
        ok = 1'b1;
      end
      if (ok && vel < 128) begin
        r.led_write     = 1'b1;
        r.color_index   = 7'(vel);
        r.lighting_type = (chan <= 2) ? 4'(chan) : 4'd0;
      end else begin
        // no write: position reads as zero
        r.led_column = 4'd0;
        r.led_row    = 3'd0;
      end
    end else if (cin == CIN_CC) begin
      if (b1 >= CTL_LOW && b1 <= CTL_HIGH && b2 < 8'd128) begin
        ctl_off         = b1 - CTL_LOW;
        r.led_write     = 1'b1;
        r.led_column    = 4'd9;
        r.led_row       = CTL_ROW_MAP[ctl_off[2:0]];
        r.color_index   = b2[6:0];
        r.lighting_type = b0[3:0];
      end
    end else if (cin >= CIN_SYSEX && cin <= CIN_END3) begin
      if (sh_count >= SYSEX_LIMIT - 3) begin
        // overflow: message dropped, this packet goes nowhere
        sh_count = '0;
      end else begin
        store_byte(b0);
        if (cin != CIN_END1) store_byte(b1);
        if (cin == CIN_SYSEX || cin == CIN_END3) store_byte(b2);
        if (cin != CIN_SYSEX) begin
          len    = int'(sh_count);
          hdr_ok = (len >= 8);
          if (hdr_ok) begin
            for (i = 0; i < 6; i++) if (sh_head[i] != SYSEX_HDR[i]) hdr_ok = 1'b0;
          end
          if (hdr_ok) begin
            case (sh_head[6])
              MSG_LAYOUT: if (sh_head[7] <= MAX_LAYOUT) sh_layout = sh_head[7][1:0];
              MSG_CHAL:   r.challenge_reply = 1'b1;
              MSG_TEXT: begin
                cmd = head_at(7, len);
                if (cmd == CMD_STATE) begin
                  sh_flags[FLAG_PLAY] = (head_at(8, len) == CH_PLAY);
                  sh_flags[FLAG_REC]  = (head_at(9, len) == CH_REC);
                  sh_flags[FLAG_SESS] = (head_at(10, len) == CH_SESS);
                end else if (cmd == CMD_TEMPO) begin
                  t = digit_at(8, len) * 32'd100 + digit_at(9, len) * 32'd10
                      + digit_at(10, len);
                  sh_tempo = t[15:0];
                  t = digit_at(11, len) * 32'd10 + digit_at(12, len);
                  sh_numer = t[7:0];
                  t = digit_at(13, len) * 32'd10 + digit_at(14, len);
                  sh_denom = t[7:0];
                  sh_flags[FLAG_DOWN] = (head_at(15, len) == CH_DOWN);
                  sh_flags[FLAG_UP]   = (head_at(15, len) == CH_UP);
                end
              end
              default: ;
            endcase
          end
          sh_count = '0;
        end
      end
    end
    r.layout          = sh_layout;
    r.tempo           = sh_tempo;
    r.sig_numerator   = sh_numer;
    r.sig_denominator = sh_denom;
    r.transport_flags = sh_flags;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("MISMATCH word %0d %s: got %0d, expected %0d", results_seen, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_packet(input logic [3:0] cin, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input bit typed, input result_t want);
    result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    r = decode_packet(cin, b0, b1, b2);
    pending_results.push_back(typed ? want : r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b2, b1, b0};
    s_axis_tuser  <= cin;
    do @(posedge clk_i); while (!s_axis_tready);
    packets_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] mostly(input logic [7:0] c);
    return ($urandom_range(3) != 0) ? c : rnd8();
  endfunction

  function automatic logic [7:0] text_digit();
    return ($urandom_range(9) != 0) ? DIGIT_ZERO + 8'($urandom_range(9)) : rnd8();
  endfunction

  task automatic send_channel();
    logic [3:0] cin;
    logic [7:0] b1;
    logic [7:0] b2;
    if ($urandom_range(2) != 0) begin
      cin = $urandom_range(1) ? CIN_NOTE_ON : CIN_NOTE_OFF;
      if ($urandom_range(4) == 0) b1 = rnd8();
      else if (sh_layout == LAYOUT_DRUM) b1 = 8'($urandom_range(110, 30));
      else b1 = 8'($urandom_range(95, 5));
    end else begin
      cin = CIN_CC;
      b1  = ($urandom_range(4) != 0) ? 8'($urandom_range(CTL_HIGH, CTL_LOW)) : rnd8();
    end
    b2 = ($urandom_range(9) != 0) ? 8'($urandom_range(127)) : 8'($urandom_range(255, 128));
    send_packet(cin, rnd8(), b1, b2, 1'b0, '0);
  endtask

  // builds one system-exclusive message in sysex_buf and sends it in packets
  task automatic send_message(input bit overlong);
    int k;
    int n;
    sysex_buf.delete();
    for (k = 0; k < 6; k++) sysex_buf.push_back(SYSEX_HDR[k]);
    if ($urandom_range(9) == 0) sysex_buf[$urandom_range(5)] = rnd8();
    case ($urandom_range(9))
      0, 1, 2: begin
        sysex_buf.push_back(MSG_LAYOUT);
        sysex_buf.push_back(($urandom_range(7) == 0) ? rnd8() : 8'($urandom_range(3)));
      end
      3: sysex_buf.push_back(MSG_CHAL);
      4, 5: begin
        sysex_buf.push_back(MSG_TEXT);
        sysex_buf.push_back(CMD_STATE);
        sysex_buf.push_back(mostly(CH_PLAY));
        sysex_buf.push_back(mostly(CH_REC));
        sysex_buf.push_back(mostly(CH_SESS));
      end
      6, 7: begin
        sysex_buf.push_back(MSG_TEXT);
        sysex_buf.push_back(CMD_TEMPO);
        repeat (7) sysex_buf.push_back(text_digit());
        sysex_buf.push_back($urandom_range(1) ? mostly(CH_DOWN) : mostly(CH_UP));
      end
      8: begin
        // name or unknown text
        sysex_buf.push_back(MSG_TEXT);
        repeat ($urandom_range(8, 1)) sysex_buf.push_back(rnd8());
      end
      default: sysex_buf.push_back(rnd8());
    endcase
    if ($urandom_range(4) == 0) repeat ($urandom_range(4, 1)) sysex_buf.push_back(rnd8());
    if (overlong) repeat ($urandom_range(70, 50)) sysex_buf.push_back(rnd8());
    sysex_buf.push_back(SYSEX_EOX);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(sysex_buf.size(), 1);
      while (sysex_buf.size() > n) void'(sysex_buf.pop_back());
    end
    messages_sent++;
    k = 0;
    while (sysex_buf.size() - k > 3) begin
      send_packet(CIN_SYSEX, sysex_buf[k], sysex_buf[k+1], sysex_buf[k+2], 1'b0, '0);
      k += 3;
      if ($urandom_range(19) == 0) send_channel();
    end
    n = sysex_buf.size() - k;
    // unused bytes of the closing packet carry junk
    send_packet((n == 1) ? CIN_END1 : (n == 2) ? CIN_END2 : CIN_END3, sysex_buf[k],
                (n > 1) ? sysex_buf[k+1] : rnd8(), (n > 2) ? sysex_buf[k+2] : rnd8(),
                1'b0, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("usb_midi_led_command_decoder test failed");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", 1, 0);
      end else begin
        mon_want                = pending_results.pop_front();
        mon_got.led_write       = m_axis_tuser;
        mon_got.led_column      = m_axis_tdata[3:0];
        mon_got.led_row         = m_axis_tdata[6:4];
        mon_got.color_index     = m_axis_tdata[13:7];
        mon_got.lighting_type   = m_axis_tdata[17:14];
        mon_got.challenge_reply = m_axis_tdata[18];
        mon_got.layout          = m_axis_tdata[20:19];
        mon_got.tempo           = m_axis_tdata[36:21];
        mon_got.sig_numerator   = m_axis_tdata[44:37];
        mon_got.sig_denominator = m_axis_tdata[52:45];
        mon_got.transport_flags = m_axis_tdata[57:53];
        check_field("led_write", int'(mon_got.led_write), int'(mon_want.led_write));
        check_field("led_column", int'(mon_got.led_column), int'(mon_want.led_column));
        check_field("led_row", int'(mon_got.led_row), int'(mon_want.led_row));
        check_field("color_index", int'(mon_got.color_index), int'(mon_want.color_index));
        check_field("lighting_type", int'(mon_got.lighting_type),
                    int'(mon_want.lighting_type));
        check_field("challenge_reply", int'(mon_got.challenge_reply),
                    int'(mon_want.challenge_reply));
        check_field("layout", int'(mon_got.layout), int'(mon_want.layout));
        check_field("tempo", int'(mon_got.tempo), int'(mon_want.tempo));
        check_field("sig_numerator", int'(mon_got.sig_numerator),
                    int'(mon_want.sig_numerator));
        check_field("sig_denominator", int'(mon_got.sig_denominator),
                    int'(mon_want.sig_denominator));
        check_field("transport_flags", int'(mon_got.transport_flags),
                    int'(mon_want.transport_flags));
        check_field("zero fill", int'(m_axis_tdata[63:58]), 0);
        if (mon_got.led_write) led_writes_seen++;
        if (mon_got.challenge_reply) challenges_seen++;
      end
      results_seen++;
    end
  end

  initial begin
    int  i;
    int  pick;
    bit  paused;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    paused        = 1'b0;
    sh_layout     = '0;
    sh_count      = '0;
    sh_tempo      = '0;
    sh_numer      = '0;
    sh_denom      = '0;
    sh_flags      = '0;
    for (i = 0; i < HEAD_DEPTH; i++) sh_head[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_packet(DIR_TAB[i].cin, DIR_TAB[i].b0, DIR_TAB[i].b1, DIR_TAB[i].b2,
                  DIR_TAB[i].typed, DIR_TAB[i].want);
    // close the tempo text: 'U' then terminator
    send_packet(CIN_END2, CH_UP, SYSEX_EOX, 8'h00, 1'b0, '0);
    hold_until_drained();

    while (packets_sent < DIR_ROWS + RANDOM_ITEMS) begin
      calm = (packets_sent >= 900 && packets_sent < 1200);
      if (!paused && packets_sent >= 1500) begin
        hold_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 45) send_message(1'b0);
      else if (pick < 48) send_message(1'b1);
      else if (pick < 85) send_channel();
      else send_packet(4'($urandom_range(15)), rnd8(), rnd8(), rnd8(), 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d packets in %0d sysex messages, %0d words checked",
             packets_sent, messages_sent, results_seen);
    $display("  %0d LED writes, %0d challenge replies, %0d mismatches",
             led_writes_seen, challenges_seen, err_count);
    if (err_count == 0) begin
      $display("usb_midi_led_command_decoder test passed");
    end else begin
      $display("usb_midi_led_command_decoder test failed");
    end
    $finish;
  end

endmodule

// File: usb_midi_led_command_decoder.f
rtl/core/umlcd_pkg.sv
rtl/core/umlcd_front.sv
rtl/core/umlcd_queue.sv
rtl/core/umlcd_back.sv
rtl/core/usb_midi_led_command_decoder.sv
test/usb_midi_led_command_decoder_tb.sv
